// File: design/quaternion_alu_top_assert.svh
// assertion macros for the quaternion alu top level
// depends on i_clk and i_rst_n being visible where a macro is used
`ifndef QUATERNION_ALU_TOP_ASSERT_SVH
`define QUATERNION_ALU_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define QALU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define QALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/qalu_pkg.sv
// shared types, op codes and product wiring tables for the quaternion alu
// no dependencies
`default_nettype none

package qalu_pkg;

    localparam int PART_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int OP_WIDTH       = 4;
    localparam int NUM_LANES      = 4;

    // operation codes carried in tuser
    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD        = 4'd0,
        OP_SUB        = 4'd1,
        OP_MUL        = 4'd2,
        OP_CONJ       = 4'd3,
        OP_MODULUS    = 4'd4,
        OP_SCALAR_ADD = 4'd5,
        OP_SCALAR_SUB = 4'd6,
        OP_SCALAR_MUL = 4'd7,
        OP_EQUAL      = 4'd8
    } t_op;

    // what a lane hands to its second stage
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_SIMPLE,
        SEL_DOT,
        SEL_SCALE
    } t_lane_sel;

    // per-lane control
    typedef struct packed {
        t_op        op;
        logic       is_real;
        logic [3:0] neg;
    } t_lane_ctl;

    // hamilton product: lane l pairs a[k] with b[l ^ k]
    function automatic logic [1:0] lane_src(input int lane, input int k);
        logic [1:0] l2;
        logic [1:0] k2;
        l2 = lane[1:0];
        k2 = k[1:0];
        return l2 ^ k2;
    endfunction

    // hamilton product: terms that are subtracted, one bit per term
    function automatic logic [3:0] lane_neg(input int lane);
        logic [3:0] m;
        case (lane)
            0:       m = 4'b1110;
            1:       m = 4'b1000;
            2:       m = 4'b0010;
            3:       m = 4'b0100;
            default: m = 4'b0000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: design/qalu_lane.sv
// one lane of the quaternion alu: computes one result part, its clip flag,
// the square of its own a part and the a/b match bit; depends on qalu_pkg
`default_nettype none

module qalu_lane import qalu_pkg::*; #(
    parameter int PART_WIDTH = PART_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire t_lane_ctl                      i_ctl,
    input  wire logic signed [PART_WIDTH-1:0]   i_a [4],
    input  wire logic signed [PART_WIDTH-1:0]   i_y [4],
    input  wire logic signed [PART_WIDTH-1:0]   i_a_own,
    input  wire logic signed [PART_WIDTH-1:0]   i_b_own,
    input  wire logic signed [PART_WIDTH-1:0]   i_s,
    output logic signed [PART_WIDTH-1:0]        o_part,
    output logic                                o_sat,
    output logic [2*PART_WIDTH-1:0]             o_sq,
    output logic                                o_eq
);

    localparam int W  = PART_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int ST = W + 2;

    localparam logic signed [SW-1:0] SUM_MAX  = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN  = ~SUM_MAX;
    localparam logic signed [W-1:0]  PART_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0]  PART_MIN = {1'b1, {(W - 1){1'b0}}};

    logic signed [W-1:0]  w_mx [4];
    logic signed [W-1:0]  w_my [4];
    logic signed [PW-1:0] n_p [4];
    logic signed [ST-1:0] n_simple;
    t_lane_sel            n_sel;

    logic signed [PW-1:0] r_p [4];
    logic signed [ST-1:0] r_simple;
    t_lane_sel            r_sel;
    logic [3:0]           r_neg;
    logic                 r_eq1;

    logic signed [SW-1:0] w_dot;
    logic signed [SW-1:0] w_val;
    logic signed [W-1:0]  n_part;
    logic                 n_sat;

    // stage 1: operand selection for the multipliers and the add path
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_mx[k] = '0;
            w_my[k] = '0;
        end
        n_simple = '0;
        n_sel    = SEL_ZERO;
        case (i_ctl.op)
            OP_ADD: begin
                n_simple = ST'(i_a_own) + ST'(i_b_own);
                n_sel    = SEL_SIMPLE;
            end
            OP_SUB: begin
                n_simple = ST'(i_a_own) - ST'(i_b_own);
                n_sel    = SEL_SIMPLE;
            end
            OP_MUL: begin
                for (int k = 0; k < 4; k++) begin
                    w_mx[k] = i_a[k];
                    w_my[k] = i_y[k];
                end
                n_sel = SEL_DOT;
            end
            OP_CONJ: begin
                n_simple = i_ctl.is_real ? ST'(i_a_own) : -ST'(i_a_own);
                n_sel    = SEL_SIMPLE;
            end
            OP_MODULUS: begin
                // square goes to the merge stage, the part itself is zero
                w_mx[0] = i_a_own;
                w_my[0] = i_a_own;
                n_sel   = SEL_ZERO;
            end
            OP_SCALAR_ADD: begin
                n_simple = i_ctl.is_real ? ST'(i_a_own) + ST'(i_s) : ST'(i_a_own);
                n_sel    = SEL_SIMPLE;
            end
            OP_SCALAR_SUB: begin
                n_simple = i_ctl.is_real ? ST'(i_a_own) - ST'(i_s) : ST'(i_a_own);
                n_sel    = SEL_SIMPLE;
            end
            OP_SCALAR_MUL: begin
                w_mx[0] = i_a_own;
                w_my[0] = i_s;
                n_sel   = SEL_SCALE;
            end
            OP_EQUAL: begin
                n_sel = SEL_ZERO;
            end
            default: begin
                n_sel = SEL_ZERO;
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            n_p[k] = PW'(w_mx[k]) * PW'(w_my[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= n_p[k];
            end
            r_simple <= n_simple;
            r_sel    <= n_sel;
            r_neg    <= i_ctl.neg;
            r_eq1    <= (i_a_own == i_b_own);
        end
    end

    // stage 2: signed sum of the four products, floor shift, clip
    always_comb begin
        w_dot = '0;
        for (int k = 0; k < 4; k++) begin
            w_dot = r_neg[k] ? w_dot - SW'(r_p[k]) : w_dot + SW'(r_p[k]);
        end
        case (r_sel)
            SEL_DOT:    w_val = w_dot >>> FRAC_BITS;
            SEL_SCALE:  w_val = SW'(r_p[0]) >>> FRAC_BITS;
            SEL_SIMPLE: w_val = SW'(r_simple);
            default:    w_val = '0;
        endcase
        if (w_val > SUM_MAX) begin
            n_part = PART_MAX;
            n_sat  = 1'b1;
        end else if (w_val < SUM_MIN) begin
            n_part = PART_MIN;
            n_sat  = 1'b1;
        end else begin
            n_part = w_val[W-1:0];
            n_sat  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_part <= n_part;
            o_sat  <= n_sat;
            o_sq   <= r_p[0];
            o_eq   <= r_eq1;
        end
    end

endmodule

`default_nettype wire

// File: design/qalu_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on qalu_pkg for the default input width
`default_nettype none

module qalu_sqrt import qalu_pkg::*; #(
    parameter int IN_W = 2 * PART_WIDTH_DEF + 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [IN_W-1:0]       i_n,
    output logic [IN_W/2-1:0]          o_root
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  r_rem [ROOT_W];
    logic [ROOT_W-1:0] r_q   [ROOT_W];
    logic [IN_W-1:0]   r_n   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_q_in;
        logic [IN_W-1:0]   w_n_in;
        logic [REM_W-1:0]  w_rem_sh;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_q_in   = '0;
            assign w_n_in   = i_n;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_q_in   = r_q[k-1];
            assign w_n_in   = r_n[k-1];
        end

        // bring down the next two radicand bits and try the next root bit
        always_comb begin
            w_rem_sh = {w_rem_in[REM_W-3:0], w_n_in[IN_W-1 -: 2]};
            w_trial  = {w_q_in, 2'b01};
            w_ge     = (w_rem_sh >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_rem_sh - w_trial : w_rem_sh;
                r_q[k]   <= {w_q_in[ROOT_W-2:0], w_ge};
                r_n[k]   <= w_n_in << 2;
            end
        end
    end

    assign o_root = r_q[ROOT_W-1];

endmodule

`default_nettype wire

// File: design/qalu_merge.sv
// merge stage: combines lane parts, flags and squares, runs the modulus root
// and picks the final result by op; depends on qalu_pkg and qalu_sqrt
`default_nettype none

module qalu_merge import qalu_pkg::*; #(
    parameter int PART_WIDTH = PART_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire t_op                           i_op,
    input  wire logic signed [PART_WIDTH-1:0]  i_part [4],
    input  wire logic [3:0]                    i_sat,
    input  wire logic [2*PART_WIDTH-1:0]       i_sq [4],
    input  wire logic [3:0]                    i_eq,
    output logic [4*PART_WIDTH-1:0]            o_parts,
    output logic                               o_equal,
    output logic                               o_sat
);

    localparam int W      = PART_WIDTH;
    localparam int SW     = 2 * W + 2;
    localparam int ROOT_W = SW / 2;
    localparam int LAST   = ROOT_W - 1;

    localparam logic [W-1:0] PART_MAX = {1'b0, {(W - 1){1'b1}}};

    logic [SW-1:0]     r_sum;
    logic [4*W-1:0]    r_parts;
    logic              r_sat;
    logic              r_eq;
    t_op               r_op;

    logic [4*W-1:0]    r_d_parts [ROOT_W];
    logic              r_d_sat   [ROOT_W];
    logic              r_d_eq    [ROOT_W];
    t_op               r_d_op    [ROOT_W];

    logic [ROOT_W-1:0] w_root;
    logic              w_root_ovf;
    logic [W-1:0]      w_root_clip;

    // combine the lanes: sum of squares, clip flags, part matches
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= SW'(i_sq[0]) + SW'(i_sq[1]) + SW'(i_sq[2]) + SW'(i_sq[3]);
            r_parts <= {i_part[3], i_part[2], i_part[1], i_part[0]};
            r_sat   <= |i_sat;
            r_eq    <= &i_eq;
            r_op    <= i_op;
        end
    end

    qalu_sqrt #(
        .IN_W (SW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_n    (r_sum),
        .o_root (w_root)
    );

    // hold the other results while the root is worked out
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_parts[0] <= r_parts;
            r_d_sat[0]   <= r_sat;
            r_d_eq[0]    <= r_eq;
            r_d_op[0]    <= r_op;
            for (int i = 1; i < ROOT_W; i++) begin
                r_d_parts[i] <= r_d_parts[i-1];
                r_d_sat[i]   <= r_d_sat[i-1];
                r_d_eq[i]    <= r_d_eq[i-1];
                r_d_op[i]    <= r_d_op[i-1];
            end
        end
    end

    // root above the part range clips
    assign w_root_ovf  = |w_root[ROOT_W-1:W-1];
    assign w_root_clip = w_root_ovf ? PART_MAX : w_root[W-1:0];

    // final pick by op
    always_comb begin
        case (r_d_op[LAST])
            OP_MODULUS: begin
                o_parts = {{(3 * W){1'b0}}, w_root_clip};
                o_sat   = w_root_ovf;
                o_equal = 1'b0;
            end
            OP_EQUAL: begin
                o_parts = '0;
                o_sat   = 1'b0;
                o_equal = r_d_eq[LAST];
            end
            default: begin
                o_parts = r_d_parts[LAST];
                o_sat   = r_d_sat[LAST];
                o_equal = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/quaternion_alu_top.sv
// channel  dir  beat fields (lowest bit up)
// s_axis   in   tuser: op; tdata: a_real a_i a_j a_k b_real b_i b_j b_k scalar
// m_axis   out  tuser: equal saturated; tdata: r_real r_i r_j r_k
//
// one beat accepted per clock while the skid entry is empty, fully pipelined
// across four part lanes; depth set by the square root, one root bit a stage
// synchronous active-low reset clears the valid pipeline, output and skid
// a stalled output fills one skid entry, then the whole pipeline holds
//
// top level of the quaternion alu; depends on qalu_pkg, qalu_lane,
// qalu_merge and quaternion_alu_top_assert.svh
`default_nettype none

`include "quaternion_alu_top_assert.svh"

module quaternion_alu_top import qalu_pkg::*; #(
    parameter int PART_WIDTH = PART_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k, scalar, zero fill
    input  wire logic [((9*PART_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    // op
    input  wire logic [OP_WIDTH-1:0]                    i_s_axis_tuser,
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    // r_real, r_i, r_j, r_k, zero fill
    output logic [((4*PART_WIDTH+7)/8)*8-1:0]           o_m_axis_tdata,
    // equal, saturated
    output logic [1:0]                                  o_m_axis_tuser
);

    localparam int W      = PART_WIDTH;
    localparam int PW     = 2 * W;
    localparam int OUT_W  = ((4 * W + 7) / 8) * 8;
    localparam int ROOT_W = W + 1;
    localparam int DEPTH  = ROOT_W + 4;

    // input stage
    logic signed [W-1:0] r_a [4];
    logic signed [W-1:0] r_b [4];
    logic signed [W-1:0] r_s;
    t_op                 r_op;
    t_op                 r_op_l1;
    t_op                 r_op_l2;

    logic [DEPTH-1:0]    r_vld;
    logic [DEPTH-1:0]    n_vld;
    logic                w_adv;
    logic                w_in_acc;
    logic                w_arrive;

    // lane wiring
    logic signed [W-1:0] w_y [4][4];
    t_lane_ctl           w_ctl [4];
    logic signed [W-1:0] w_part [4];
    logic [3:0]          w_sat;
    logic [PW-1:0]       w_sq [4];
    logic [3:0]          w_eq;

    // merge result
    logic [4*W-1:0]      w_res_parts;
    logic                w_res_eq;
    logic                w_res_sat;

    // output register and skid entry
    logic                r_out_vld;
    logic [4*W-1:0]      r_out_parts;
    logic                r_out_eq;
    logic                r_out_sat;
    logic                r_skid_vld;
    logic [4*W-1:0]      r_skid_parts;
    logic                r_skid_eq;
    logic                r_skid_sat;
    logic                w_out_free;

    assign w_adv           = !r_skid_vld;
    assign o_s_axis_tready = w_adv;
    assign w_in_acc        = i_s_axis_tvalid && w_adv;
    assign w_arrive        = w_adv && r_vld[DEPTH-1];
    assign w_out_free      = !r_out_vld || i_m_axis_tready;

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int p = 0; p < 4; p++) begin
                r_a[p] <= i_s_axis_tdata[p*W +: W];
                r_b[p] <= i_s_axis_tdata[(p+4)*W +: W];
            end
            r_s     <= i_s_axis_tdata[8*W +: W];
            r_op    <= t_op'(i_s_axis_tuser);
            r_op_l1 <= r_op;
            r_op_l2 <= r_op_l1;
        end
    end

    // valid bits follow the beats down the pipeline
    assign n_vld = {r_vld[DEPTH-2:0], w_in_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    // four lanes, one per result part
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        for (genvar k = 0; k < 4; k++) begin : g_src
            assign w_y[l][k] = r_b[lane_src(l, k)];
        end

        assign w_ctl[l] = '{op: r_op, is_real: (l == 0), neg: lane_neg(l)};

        qalu_lane #(
            .PART_WIDTH (PART_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_ctl   (w_ctl[l]),
            .i_a     (r_a),
            .i_y     (w_y[l]),
            .i_a_own (r_a[l]),
            .i_b_own (r_b[l]),
            .i_s     (r_s),
            .o_part  (w_part[l]),
            .o_sat   (w_sat[l]),
            .o_sq    (w_sq[l]),
            .o_eq    (w_eq[l])
        );
    end

    qalu_merge #(
        .PART_WIDTH (PART_WIDTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_op    (r_op_l2),
        .i_part  (w_part),
        .i_sat   (w_sat),
        .i_sq    (w_sq),
        .i_eq    (w_eq),
        .o_parts (w_res_parts),
        .o_equal (w_res_eq),
        .o_sat   (w_res_sat)
    );

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_arrive;
            end
        end else if (w_arrive) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_vld) begin
                r_out_parts <= r_skid_parts;
                r_out_eq    <= r_skid_eq;
                r_out_sat   <= r_skid_sat;
            end else begin
                r_out_parts <= w_res_parts;
                r_out_eq    <= w_res_eq;
                r_out_sat   <= w_res_sat;
            end
        end else if (w_arrive) begin
            r_skid_parts <= w_res_parts;
            r_skid_eq    <= w_res_eq;
            r_skid_sat   <= w_res_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'(r_out_parts);
    assign o_m_axis_tuser  = {r_out_sat, r_out_eq};

    // checks
    `QALU_ASSERT_NOW(a_skid_behind_out, r_skid_vld, r_out_vld,
        "skid entry holds a beat while the output register is empty")
    `QALU_ASSERT_NEXT(a_stall_to_skid, w_arrive && r_out_vld && !i_m_axis_tready,
        r_skid_vld, "result arriving at a stalled output was not kept in the skid entry")
    `QALU_ASSERT_NOW(a_equal_clean, o_m_axis_tvalid && o_m_axis_tuser[0],
        (o_m_axis_tdata[4*PART_WIDTH-1:0] == '0) && !o_m_axis_tuser[1],
        "equal result carries nonzero parts or a clip flag")

endmodule

`default_nettype wire

// File: tb/tb_quaternion_alu_top.sv
// self-checking testbench for the quaternion alu top level
// depends on qalu_pkg and quaternion_alu_top; holds its own model of every operation
`timescale 1ns / 100ps

module tb_quaternion_alu_top;
    import qalu_pkg::*;

    localparam int PW    = PART_WIDTH_DEF;
    localparam int FB    = FRAC_BITS_DEF;
    localparam int IN_W  = ((9*PW+7)/8)*8;
    localparam int OUT_W = ((4*PW+7)/8)*8;

    // pipeline depth given for the top level
    localparam int LATENCY      = PW + 5;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 40;

    // codes with no operation behind them
    localparam logic [OP_WIDTH-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OP_WIDTH-1:0] OP_UNUSED_HI = 4'd15;

    localparam longint PART_MAX = (longint'(1) << (PW-1)) - 1;
    localparam longint PART_MIN = -PART_MAX - 1;

    // handy q8.8 values
    localparam logic [PW-1:0] P_MAX   = 16'h7FFF;
    localparam logic [PW-1:0] P_MIN   = 16'h8000;
    localparam logic [PW-1:0] ONE     = 16'h0100;
    localparam logic [PW-1:0] NEG_ONE = 16'hFF00;
    localparam logic [PW-1:0] HALF    = 16'h0080;

    // one result beat as it should leave the block
    typedef struct {
        logic signed [PW-1:0] r_real;
        logic signed [PW-1:0] r_i;
        logic signed [PW-1:0] r_j;
        logic signed [PW-1:0] r_k;
        logic                 equal;
        logic                 saturated;
    } t_qres;

    // quaternion arithmetic model plus queue of results still owed
    class qalu_scoreboard;
        t_qres quat_results_q[$];
        int    n_mismatch;
        int    n_beats;
        int    n_checked;
        int    n_saturated;
        int    n_equal;
        bit    clip_hit;

        function int pending_count();
            return quat_results_q.size();
        endfunction

        // clamp to the signed part range, remember any clipping
        function logic [PW-1:0] clip_part(longint v);
            longint c;
            c = v;
            if (v > PART_MAX) begin
                clip_hit = 1'b1;
                c = PART_MAX;
            end else if (v < PART_MIN) begin
                clip_hit = 1'b1;
                c = PART_MIN;
            end
            return c[PW-1:0];
        endfunction

        // arithmetic shift rounds toward minus infinity
        function longint drop_frac(longint v);
            return v >>> FB;
        endfunction

        // floor of square root, one result bit at a time
        function longint root_floor(longint n);
            longint root;
            longint cand;
            root = 0;
            for (int k = PW + 1; k >= 0; k--) begin
                cand = root | (longint'(1) << k);
                if (cand * cand <= n) root = cand;
            end
            return root;
        endfunction

        function void note_input(logic [OP_WIDTH-1:0] op, logic [IN_W-1:0] beat);
            longint        a [4];
            longint        b [4];
            longint        s;
            longint        sum;
            longint        m;
            logic [PW-1:0] r [4];
            t_qres         e;
            for (int t = 0; t < 4; t++) begin
                a[t] = longint'($signed(beat[PW*t +: PW]));
                b[t] = longint'($signed(beat[PW*(4+t) +: PW]));
                r[t] = '0;
            end
            s = longint'($signed(beat[PW*8 +: PW]));
            clip_hit = 1'b0;
            e.equal  = 1'b0;
            case (op)
                OP_ADD: for (int t = 0; t < 4; t++) r[t] = clip_part(a[t] + b[t]);
                OP_SUB: for (int t = 0; t < 4; t++) r[t] = clip_part(a[t] - b[t]);
                OP_MUL: begin
                    // hamilton product a * b, summed exactly before the shift
                    r[0] = clip_part(drop_frac(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]));
                    r[1] = clip_part(drop_frac(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]));
                    r[2] = clip_part(drop_frac(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]));
                    r[3] = clip_part(drop_frac(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]));
                end
                OP_CONJ: begin
                    r[0] = a[0][PW-1:0];
                    for (int t = 1; t < 4; t++) r[t] = clip_part(-a[t]);
                end
                OP_MODULUS: begin
                    sum = 0;
                    for (int t = 0; t < 4; t++) sum += a[t] * a[t];
                    m = root_floor(sum);
                    if (m > PART_MAX) begin
                        clip_hit = 1'b1;
                        m = PART_MAX;
                    end
                    r[0] = m[PW-1:0];
                end
                OP_SCALAR_ADD, OP_SCALAR_SUB: begin
                    r[0] = clip_part((op == OP_SCALAR_ADD) ? a[0] + s : a[0] - s);
                    for (int t = 1; t < 4; t++) r[t] = a[t][PW-1:0];
                end
                OP_SCALAR_MUL:
                    for (int t = 0; t < 4; t++) r[t] = clip_part(drop_frac(a[t] * s));
                OP_EQUAL: e.equal = (a[0] == b[0]) && (a[1] == b[1]) &&
                                    (a[2] == b[2]) && (a[3] == b[3]);
                default: ;
            endcase
            e.r_real    = r[0];
            e.r_i       = r[1];
            e.r_j       = r[2];
            e.r_k       = r[3];
            e.saturated = clip_hit;
            quat_results_q.push_back(e);
            n_beats++;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            n_mismatch++;
            if (n_mismatch <= PRINT_CAP)
                $display("[%0t] mismatch on result %0d: %s got %0d want %0d",
                         $time, n_checked, what, got, want);
        endtask

        task check_result(logic [OUT_W-1:0] beat, logic [1:0] flags);
            t_qres e;
            logic signed [PW-1:0] g [4];
            for (int t = 0; t < 4; t++) g[t] = beat[PW*t +: PW];
            if (quat_results_q.size() == 0) begin
                report_mismatch("result with nothing owed, r_real", g[0], 0);
                return;
            end
            e = quat_results_q.pop_front();
            if (g[0] !== e.r_real)       report_mismatch("r_real", g[0], e.r_real);
            if (g[1] !== e.r_i)          report_mismatch("r_i", g[1], e.r_i);
            if (g[2] !== e.r_j)          report_mismatch("r_j", g[2], e.r_j);
            if (g[3] !== e.r_k)          report_mismatch("r_k", g[3], e.r_k);
            if (flags[0] !== e.equal)    report_mismatch("equal", flags[0], e.equal);
            if (flags[1] !== e.saturated) report_mismatch("saturated", flags[1], e.saturated);
            n_checked++;
            if (e.saturated) n_saturated++;
            if (e.equal) n_equal++;
        endtask

        task drain_check();
            if (quat_results_q.size() != 0)
                report_mismatch("results never delivered, count", quat_results_q.size(), 0);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [IN_W-1:0]    s_tdata = '0;
    logic [OP_WIDTH-1:0] s_tuser = '0;
    logic               m_tready = 1'b0;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [OUT_W-1:0]   o_m_axis_tdata;
    logic [1:0]         o_m_axis_tuser;

    int  cycles = 0;
    bit  send_burst = 1'b0;

    qalu_scoreboard score = new();

    quaternion_alu_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycles,
                     score.pending_count());
            $display("Verification failed");
            $finish;
        end
    end

    // pack nine parts, a_real in the lowest bits
    function automatic logic [IN_W-1:0] pack_beat(
        input logic [PW-1:0] ar, ai, aj, ak, br, bi, bj, bk, sc);
        logic [IN_W-1:0] v;
        v = '0;
        v[9*PW-1:0] = {sc, bk, bj, bi, br, ak, aj, ai, ar};
        return v;
    endfunction

    // mix of full range, small values and edge values
    function automatic logic [PW-1:0] random_part();
        logic [PW-1:0] v;
        case ($urandom_range(0, 3))
            0: v = PW'($urandom_range(0, 2047) - 1024);
            1: begin
                case ($urandom_range(0, 6))
                    0: v = P_MAX;
                    1: v = P_MIN;
                    2: v = '0;
                    3: v = '1;
                    4: v = 16'h0001;
                    5: v = ONE;
                    default: v = NEG_ONE;
                endcase
            end
            default: v = PW'($urandom);
        endcase
        return v;
    endfunction

    // one input beat; entered and left at a falling edge
    task automatic send_beat(input logic [OP_WIDTH-1:0] op, input logic [IN_W-1:0] beat);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= beat;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        score.note_input(op, beat);
        @(negedge i_clk);
    endtask

    // hold the sender until the block has handed back everything
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (score.pending_count() != 0) @(negedge i_clk);
    endtask

    // result side: random stalls with calm stretches
    initial begin
        int gap;
        int n;
        n = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = ((n / 130) % 4 == 3) ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            score.check_result(o_m_axis_tdata, o_m_axis_tuser);
            n++;
            @(negedge i_clk);
        end
    end

    // stimulus
    initial begin
        logic [PW-1:0]       p [9];
        logic [OP_WIDTH-1:0] op;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        send_beat(OP_ADD, pack_beat(P_MAX, P_MAX, P_MIN, ONE, P_MAX, 16'h0001, P_MIN,
                                    NEG_ONE, '0));
        send_beat(OP_ADD, pack_beat(ONE, NEG_ONE, 16'h0123, 16'hFEDC, HALF, ONE, 16'h0011,
                                    16'h0100, '0));
        send_beat(OP_SUB, pack_beat(P_MIN, P_MAX, '0, ONE, P_MAX, P_MIN, '0, ONE, '0));
        // i times j gives k
        send_beat(OP_MUL, pack_beat('0, ONE, '0, '0, '0, '0, ONE, '0, '0));
        send_beat(OP_MUL, pack_beat(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX,
                                    P_MAX, '0));
        send_beat(OP_MUL, pack_beat(P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN,
                                    P_MIN, '0));
        // small negative products round down
        send_beat(OP_MUL, pack_beat('1, 16'h0003, 16'hFFFD, 16'h0005, 16'h0001, '1,
                                    16'h0007, 16'h0002, '0));
        // negating the most negative part clips
        send_beat(OP_CONJ, pack_beat(P_MIN, P_MIN, P_MAX, '0, '0, '0, '0, '0, '0));
        send_beat(OP_CONJ, pack_beat(ONE, NEG_ONE, 16'h0005, 16'hFFFB, P_MAX, '0, '0, '0,
                                     ONE));
        send_beat(OP_MODULUS, pack_beat(P_MIN, P_MIN, P_MIN, P_MIN, '0, '0, '0, '0, '0));
        send_beat(OP_MODULUS, pack_beat('0, '0, '0, '0, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX));
        send_beat(OP_MODULUS, pack_beat(16'h0300, 16'h0400, '0, '0, '0, '0, '0, '0, '0));
        send_beat(OP_MODULUS, pack_beat(P_MAX, '0, '0, '0, '0, '0, '0, '0, '0));
        send_beat(OP_SCALAR_ADD, pack_beat(P_MAX, P_MIN, ONE, '1, '0, '0, '0, '0, P_MAX));
        send_beat(OP_SCALAR_ADD, pack_beat(NEG_ONE, 16'h0042, '0, P_MAX, '0, '0, '0, '0,
                                           ONE));
        send_beat(OP_SCALAR_SUB, pack_beat(P_MIN, ONE, P_MIN, '0, '0, '0, '0, '0, P_MAX));
        send_beat(OP_SCALAR_SUB, pack_beat(P_MAX, '0, '1, ONE, '0, '0, '0, '0, P_MIN));
        send_beat(OP_SCALAR_MUL, pack_beat(P_MAX, P_MIN, NEG_ONE, 16'h0003, '0, '0, '0,
                                           '0, P_MIN));
        send_beat(OP_SCALAR_MUL, pack_beat('1, 16'h0005, 16'hFF80, ONE, '0, '0, '0, '0,
                                           HALF));
        send_beat(OP_EQUAL, pack_beat(ONE, 16'h1234, P_MIN, P_MAX, ONE, 16'h1234, P_MIN,
                                      P_MAX, ONE));
        send_beat(OP_EQUAL, pack_beat(ONE, 16'h1234, P_MIN, P_MAX, ONE, 16'h1234, P_MIN,
                                      16'h7FFE, '0));
        send_beat(OP_EQUAL, pack_beat(P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN,
                                      P_MIN, P_MAX));
        send_beat(OP_UNUSED_LO, pack_beat(P_MAX, P_MIN, ONE, NEG_ONE, P_MAX, P_MIN, ONE,
                                          NEG_ONE, P_MAX));
        send_beat(OP_UNUSED_HI, pack_beat(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX,
                                          P_MAX, P_MAX));

        // random beats over every operation
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) wait_drained();
            send_burst = ((i / 150) % 4 == 2);
            if ($urandom_range(0, 63) == 0)
                op = OP_WIDTH'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else
                op = OP_WIDTH'($urandom_range(OP_ADD, OP_EQUAL));
            for (int t = 0; t < 9; t++) p[t] = random_part();
            // equality needs matching quaternions often enough
            if (op == OP_EQUAL && $urandom_range(0, 1) == 1) begin
                for (int t = 0; t < 4; t++) p[4+t] = p[t];
                if ($urandom_range(0, 3) == 0) p[4 + $urandom_range(0, 3)] ^= 16'h0001;
            end
            send_beat(op, pack_beat(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]));
        end
        s_tvalid <= 1'b0;

        // drain and let any stray beat show up
        while (score.pending_count() != 0) @(negedge i_clk);
        repeat (2 * LATENCY) @(negedge i_clk);
        score.drain_check();

        $display("covered %0d beats over all nine operations and the unused codes",
                 score.n_beats);
        $display("checked %0d results: %0d saturated, %0d equality hits, %0d mismatches",
                 score.n_checked, score.n_saturated, score.n_equal, score.n_mismatch);
        if (score.n_mismatch == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: quaternion_alu_top.f
+incdir+design
design/qalu_pkg.sv
design/qalu_lane.sv
design/qalu_sqrt.sv
design/qalu_merge.sv
design/quaternion_alu_top.sv
tb/tb_quaternion_alu_top.sv
